/* hdl/kpft_pkg.sv */
package kpft_pkg;

   localparam int KDIM   = 3;
   localparam int KWORDS = 9;
   localparam int WBITS  = 32;
   localparam int OBITS  = 16;

   localparam logic [OBITS-1:0] MAX16 = 16'hffff;
   localparam logic [WBITS-1:0] MAG_MASK = 32'h7fff_ffff;

   localparam logic CSR_KERNEL_ROWS = 1'b0;
   localparam logic CSR_KERNEL_COLS = 1'b1;

   typedef logic [WBITS-1:0] word_type;
   typedef logic [KWORDS-1:0][WBITS-1:0] kernel_type;
   typedef logic [KWORDS-1:0] mask_type;

endpackage

/* hdl/kpft_match.sv */
module kpft_match (
   input  kpft_pkg::kernel_type a,
   input  kpft_pkg::kernel_type b,
   input  kpft_pkg::mask_type   active,
   output logic                 same
);

   kpft_pkg::mask_type word_ok;

   always_comb begin
      for (int k = 0; k < kpft_pkg::KWORDS; k++) begin
         // plus and minus zero compare equal
         word_ok[k] = !active[k] || (a[k] == b[k]) ||
                      (((a[k] | b[k]) & kpft_pkg::MAG_MASK) == '0);
      end
   end

   assign same = &word_ok;

endmodule

/* hdl/kernel_pattern_frequency_table.sv */
// channel | ports                                   | direction
// req     | req_valid/req_ready, weight_0..8, last  | in, one kernel of nine words per item
// rsp     | rsp_valid/rsp_ready, pattern_0..8, etc  | out, top patterns then summary
// csr     | csr_valid/csr_ready, index, data        | in, kernel_rows / kernel_cols
//
// one item at a time: lookup scans the stored entries, one entry per cycle
// through the entry memory read port; the next item is taken after the lookup
// a group end adds up to four exchange passes over the stored entries,
// then up to three top pattern words and the summary word
// reset is synchronous; table is emptied logically, memories are not cleared
// rsp stalls hold the block in its emit states; req_ready is low until done
module kernel_pattern_frequency_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_weight_0,
   input  logic [31:0] req_weight_1,
   input  logic [31:0] req_weight_2,
   input  logic [31:0] req_weight_3,
   input  logic [31:0] req_weight_4,
   input  logic [31:0] req_weight_5,
   input  logic [31:0] req_weight_6,
   input  logic [31:0] req_weight_7,
   input  logic [31:0] req_weight_8,
   input  logic        req_last_in_group,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pattern_0,
   output logic [31:0] rsp_pattern_1,
   output logic [31:0] rsp_pattern_2,
   output logic [31:0] rsp_pattern_3,
   output logic [31:0] rsp_pattern_4,
   output logic [31:0] rsp_pattern_5,
   output logic [31:0] rsp_pattern_6,
   output logic [31:0] rsp_pattern_7,
   output logic [31:0] rsp_pattern_8,
   output logic [15:0] rsp_count_value,
   output logic [15:0] rsp_total_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_SORT_LD, S_SORT_SCAN, S_SORT_END,
      S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT, S_SUM_LD, S_SUM_WAIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [1:0] rows_ff, cols_ff;

   // item and table bookkeeping
   kpft_pkg::kernel_type key_ff;
   kpft_pkg::mask_type   act_ff;
   logic                 last_ff;
   logic [CW-1:0]        distinct_ff;
   logic [15:0]          total_ff;

   // scan pointers
   logic [CW-1:0] iss_ff;
   logic [CW-1:0] chk_idx_ff;
   logic          chk_vld_ff;
   logic          head_ff;
   logic [2:0]    pass_ff;
   logic [15:0]   sum_ff;

   // sort carry
   kpft_pkg::kernel_type  cur_pat_ff;
   logic [COUNT_BITS-1:0] cur_cnt_ff;

   // entry memories
   kpft_pkg::kernel_type  pat_mem [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];
   kpft_pkg::kernel_type  rd_pat_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;

   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   kpft_pkg::kernel_type  wr_pat;
   logic [COUNT_BITS-1:0] wr_cnt;
   logic [IW-1:0]         rd_addr;

   // output register
   logic                 rsp_valid_ff;
   kpft_pkg::kernel_type rsp_pat_ff;
   logic [15:0]          rsp_count_ff, rsp_total_ff;
   logic                 rsp_last_ff;

   kpft_pkg::kernel_type req_key;
   kpft_pkg::mask_type   req_act;
   logic [1:0]           rows_eff, cols_eff;
   logic                 same;
   logic                 issue;
   logic                 hit;
   logic [2:0]           pass_lim, emit_lim;
   logic [15:0]          rd_cnt16, cur_cnt16;
   logic [16:0]          sum_wide;
   logic                 table_full;
   kpft_pkg::kernel_type key_masked;

   assign req_key = {req_weight_8, req_weight_7, req_weight_6, req_weight_5, req_weight_4,
                     req_weight_3, req_weight_2, req_weight_1, req_weight_0};

   // zero rows or columns count as one
   assign rows_eff = (rows_ff == 2'd0) ? 2'd1 : rows_ff;
   assign cols_eff = (cols_ff == 2'd0) ? 2'd1 : cols_ff;

   always_comb begin
      for (int k = 0; k < kpft_pkg::KWORDS; k++) begin
         req_act[k] = (2'(k / kpft_pkg::KDIM) < rows_eff) &&
                      (2'(k % kpft_pkg::KDIM) < cols_eff);
         key_masked[k] = act_ff[k] ? key_ff[k] : '0;
      end
   end

   kpft_match u_match (
      .a      (rd_pat_ff),
      .b      (key_ff),
      .active (act_ff),
      .same   (same)
   );

   assign issue      = (iss_ff < distinct_ff);
   assign hit        = chk_vld_ff && same;
   assign table_full = (distinct_ff == DEPTH_C);
   assign pass_lim   = (distinct_ff > CW'(4)) ? 3'd4 : 3'(distinct_ff);
   assign emit_lim   = (distinct_ff > CW'(3)) ? 3'd3 : 3'(distinct_ff);

   // counts seen outside narrow to 16 bits with saturation
   assign rd_cnt16  = (rd_cnt_ff > COUNT_BITS'(kpft_pkg::MAX16)) ? kpft_pkg::MAX16
                                                                 : 16'(rd_cnt_ff);
   assign cur_cnt16 = (cur_cnt_ff > COUNT_BITS'(kpft_pkg::MAX16)) ? kpft_pkg::MAX16
                                                                  : 16'(cur_cnt_ff);
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, cur_cnt16};

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_idx_ff[IW-1:0];
      wr_pat  = cur_pat_ff;
      wr_cnt  = cur_cnt_ff;
      rd_addr = iss_ff[IW-1:0];
      unique case (state_ff)
         S_SEARCH: begin
            if (hit) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff[IW-1:0];
               wr_pat  = rd_pat_ff;
               wr_cnt  = (rd_cnt_ff == CMAX) ? CMAX : rd_cnt_ff + 1'b1;
            end else if (!issue && !table_full) begin
               // miss: append with count one
               wr_en   = 1'b1;
               wr_addr = distinct_ff[IW-1:0];
               wr_pat  = key_masked;
               wr_cnt  = COUNT_BITS'(1);
            end
         end
         S_SORT_LD: begin
            rd_addr = IW'(pass_ff);
         end
         S_SORT_SCAN: begin
            if (chk_vld_ff && !head_ff && (cur_cnt_ff < rd_cnt_ff)) begin
               wr_en = 1'b1;
            end
         end
         S_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = IW'(pass_ff);
         end
         S_EMIT_RD: begin
            rd_addr = IW'(pass_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem[wr_addr] <= wr_pat;
         cnt_mem[wr_addr] <= wr_cnt;
      end
      rd_pat_ff <= pat_mem[rd_addr];
      rd_cnt_ff <= cnt_mem[rd_addr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 2'd3;
         cols_ff <= 2'd3;
      end else if (csr_valid) begin
         if (csr_index == kpft_pkg::CSR_KERNEL_ROWS) begin
            rows_ff <= csr_data;
         end else begin
            cols_ff <= csr_data;
         end
      end
   end

   assign csr_ready = 1'b1;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         distinct_ff  <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         head_ff      <= 1'b0;
         iss_ff       <= '0;
         chk_idx_ff   <= '0;
         pass_ff      <= '0;
         sum_ff       <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  key_ff     <= req_key;
                  act_ff     <= req_act;
                  last_ff    <= req_last_in_group;
                  iss_ff     <= '0;
                  chk_vld_ff <= 1'b0;
                  state_ff   <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (hit || !issue) begin
                  if (!hit && !table_full) begin
                     distinct_ff <= distinct_ff + 1'b1;
                  end
                  if (total_ff != kpft_pkg::MAX16) begin
                     total_ff <= total_ff + 1'b1;
                  end
                  chk_vld_ff <= 1'b0;
                  pass_ff    <= '0;
                  sum_ff     <= '0;
                  if (!last_ff) begin
                     state_ff <= S_IDLE;
                  end else if (!hit && !table_full) begin
                     state_ff <= S_SORT_LD;
                  end else if (distinct_ff == '0) begin
                     state_ff <= S_SUM_LD;
                  end else begin
                     state_ff <= S_SORT_LD;
                  end
               end else begin
                  iss_ff     <= iss_ff + 1'b1;
                  chk_idx_ff <= iss_ff;
                  chk_vld_ff <= 1'b1;
               end
            end
            S_SORT_LD: begin
               // head of this pass goes into the carry register
               iss_ff     <= CW'(pass_ff) + 1'b1;
               chk_idx_ff <= CW'(pass_ff);
               chk_vld_ff <= 1'b1;
               head_ff    <= 1'b1;
               state_ff   <= S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
               head_ff <= 1'b0;
               if (head_ff || (cur_cnt_ff < rd_cnt_ff)) begin
                  cur_pat_ff <= rd_pat_ff;
                  cur_cnt_ff <= rd_cnt_ff;
               end
               if (issue) begin
                  iss_ff     <= iss_ff + 1'b1;
                  chk_idx_ff <= iss_ff;
               end else begin
                  chk_vld_ff <= 1'b0;
                  state_ff   <= S_SORT_END;
               end
            end
            S_SORT_END: begin
               sum_ff <= sum_wide[16] ? kpft_pkg::MAX16 : sum_wide[15:0];
               if (pass_ff + 3'd1 < pass_lim) begin
                  pass_ff  <= pass_ff + 3'd1;
                  state_ff <= S_SORT_LD;
               end else begin
                  pass_ff  <= '0;
                  state_ff <= S_EMIT_RD;
               end
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT_LD;
            end
            S_EMIT_LD: begin
               rsp_pat_ff   <= rd_pat_ff;
               rsp_count_ff <= rd_cnt16;
               rsp_total_ff <= total_ff;
               rsp_last_ff  <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (pass_ff + 3'd1 < emit_lim) begin
                     pass_ff  <= pass_ff + 3'd1;
                     state_ff <= S_EMIT_RD;
                  end else begin
                     state_ff <= S_SUM_LD;
                  end
               end
            end
            S_SUM_LD: begin
               rsp_pat_ff   <= '0;
               rsp_count_ff <= 16'(distinct_ff);
               rsp_total_ff <= sum_ff;
               rsp_last_ff  <= 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  distinct_ff  <= '0;
                  total_ff     <= '0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pattern_0   = rsp_pat_ff[0];
   assign rsp_pattern_1   = rsp_pat_ff[1];
   assign rsp_pattern_2   = rsp_pat_ff[2];
   assign rsp_pattern_3   = rsp_pat_ff[3];
   assign rsp_pattern_4   = rsp_pat_ff[4];
   assign rsp_pattern_5   = rsp_pat_ff[5];
   assign rsp_pattern_6   = rsp_pat_ff[6];
   assign rsp_pattern_7   = rsp_pat_ff[7];
   assign rsp_pattern_8   = rsp_pat_ff[8];
   assign rsp_count_value = rsp_count_ff;
   assign rsp_total_value = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

   // table never grows past its depth
   a_depth: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   // no memory write while waiting for a new item
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("memory write while idle");

   // results only come out of the emit states
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_EMIT_WAIT || state_ff == S_SUM_WAIT))
      else $error("result valid outside emit");

   // summary delivery empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM_WAIT && rsp_ready) |=> (distinct_ff == '0 && total_ff == '0))
      else $error("table not cleared after summary");

endmodule
